FILE: design/gccb_pkg.sv
// Shared types and constants for the grouped compartment counter bank.
package gccb_pkg;

    // Item mode codes
    localparam logic [1:0] MODE_CENSUS = 2'd0;
    localparam logic [1:0] MODE_MOVE   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    // Compartment codes; zero stands for the total
    localparam logic [3:0] COMP_TOTAL = 4'd0;
    localparam logic [3:0] COMP_S     = 4'd1;
    localparam logic [3:0] COMP_I     = 4'd4;
    localparam logic [3:0] NCOMP      = 4'd9;

    // Result field width and saturation limit
    localparam int          OUT_W   = 24;
    localparam logic [23:0] OUT_MAX = 24'hFF_FFFF;

    // APB register map
    localparam int         APB_AW        = 3;
    localparam logic [0:0] REG_TOWN_MODE = 1'b0;
    localparam logic [0:0] REG_AGE_MODE  = 1'b1;

    // Operations of the shared saturating unit
    typedef enum logic [1:0] {
        ALU_INC,
        ALU_DEC,
        ALU_ACC
    } t_alu_op;

    // Write enables of the three counter memories
    typedef struct packed {
        logic pop;
        logic nw;
        logic tot;
    } t_wr_en;

endpackage

FILE: design/gccb_if.sv
// Request and result channel interfaces of the counter bank.
interface gccb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] town;
    logic [2:0] age_group;
    logic [3:0] source_state;
    logic [3:0] target_state;

    modport source (output valid, mode, town, age_group, source_state, target_state,
                    input ready);
    modport sink   (input valid, mode, town, age_group, source_state, target_state,
                    output ready);
endinterface

interface gccb_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] current_count;
    logic [23:0] new_count;

    modport source (output valid, current_count, new_count, input ready);
    modport sink   (input valid, current_count, new_count, output ready);
endinterface

FILE: design/gccb_regs.sv
// APB configuration registers: town_mode and age_mode.
module gccb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gccb_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic                         o_town_mode,
    output logic                         o_age_mode
);
    import gccb_pkg::*;

    logic r_town_mode;
    logic r_age_mode;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes, taken in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_town_mode <= 1'b0;
            r_age_mode  <= 1'b0;
        end else if (w_wr) begin
            case (paddr[2:2])
                REG_TOWN_MODE: r_town_mode <= pwdata[0];
                REG_AGE_MODE:  r_age_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[2:2])
            REG_TOWN_MODE: prdata = {31'd0, r_town_mode};
            REG_AGE_MODE:  prdata = {31'd0, r_age_mode};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_town_mode = r_town_mode;
    assign o_age_mode  = r_age_mode;

endmodule

FILE: design/gccb_alu.sv
// Shared saturating increment, decrement and accumulate unit.
module gccb_alu #(
    parameter  int COUNT_WIDTH = 24,
    localparam int AW = (COUNT_WIDTH > gccb_pkg::OUT_W) ? COUNT_WIDTH : gccb_pkg::OUT_W
) (
    input  gccb_pkg::t_alu_op i_op,
    input  logic [AW-1:0]     i_a,
    input  logic [AW-1:0]     i_b,
    output logic [AW-1:0]     o_y
);
    import gccb_pkg::*;

    localparam int AW1 = AW + 1;

    logic [AW1-1:0] w_addend;
    logic [AW1-1:0] w_sum;
    logic [AW1-1:0] w_limit;
    logic [AW-1:0]  w_dec;
    logic [AW-1:0]  w_sat;

    // accumulate adds the operand, increment adds one
    assign w_addend = (i_op == ALU_ACC) ? {1'b0, i_b} : AW1'(1);
    assign w_sum    = {1'b0, i_a} + w_addend;
    assign w_limit  = (i_op == ALU_ACC) ? AW1'(OUT_MAX) : AW1'({COUNT_WIDTH{1'b1}});
    assign w_sat    = (w_sum > w_limit) ? w_limit[AW-1:0] : w_sum[AW-1:0];
    // decrement holds at zero
    assign w_dec    = (i_a == '0) ? '0 : i_a - AW'(1);

    always_comb begin
        case (i_op)
            ALU_INC: o_y = w_sat;
            ALU_ACC: o_y = w_sat;
            ALU_DEC: o_y = w_dec;
            default: o_y = i_a;
        endcase
    end

endmodule

FILE: design/gccb_store.sv
// Counter memories: per-compartment population, arrivals and per-cell totals.
module gccb_store #(
    parameter int COUNT_WIDTH = 24,
    parameter int NSLOT       = 4608,
    parameter int NCELL       = 512,
    parameter int SW          = 13,
    parameter int CLW         = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  gccb_pkg::t_wr_en       i_we,
    input  logic [SW-1:0]          i_pop_ra,
    input  logic [SW-1:0]          i_pop_rb,
    input  logic [SW-1:0]          i_new_ra,
    input  logic [CLW-1:0]         i_tot_ra,
    input  logic [SW-1:0]          i_pop_wa,
    input  logic [SW-1:0]          i_new_wa,
    input  logic [CLW-1:0]         i_tot_wa,
    input  logic [COUNT_WIDTH-1:0] i_pop_wd,
    input  logic [COUNT_WIDTH-1:0] i_new_wd,
    input  logic [COUNT_WIDTH-1:0] i_tot_wd,
    output logic [COUNT_WIDTH-1:0] o_pop_a,
    output logic [COUNT_WIDTH-1:0] o_pop_b,
    output logic [COUNT_WIDTH-1:0] o_new,
    output logic [COUNT_WIDTH-1:0] o_tot
);
    import gccb_pkg::*;

    logic [COUNT_WIDTH-1:0] r_pop_mem [NSLOT];
    logic [COUNT_WIDTH-1:0] r_new_mem [NSLOT];
    logic [COUNT_WIDTH-1:0] r_tot_mem [NCELL];

    // population: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we.pop) begin
            r_pop_mem[i_pop_wa] <= i_pop_wd;
        end
        if (i_rd_en) begin
            o_pop_a <= r_pop_mem[i_pop_ra];
            o_pop_b <= r_pop_mem[i_pop_rb];
        end
    end

    // arrivals
    always_ff @(posedge i_clk) begin
        if (i_we.nw) begin
            r_new_mem[i_new_wa] <= i_new_wd;
        end
        if (i_rd_en) begin
            o_new <= r_new_mem[i_new_ra];
        end
    end

    // per-cell totals
    always_ff @(posedge i_clk) begin
        if (i_we.tot) begin
            r_tot_mem[i_tot_wa] <= i_tot_wd;
        end
        if (i_rd_en) begin
            o_tot <= r_tot_mem[i_tot_ra];
        end
    end

endmodule

FILE: design/grouped_compartment_counter_bank_core.sv
// Top level of the grouped compartment counter bank: sequencer, memories, shared unit.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+-------------------------------------
//  i_item    | in  | valid/ready                    | mode, town, age_group, source/target
//  o_result  | out | valid/ready                    | current_count, new_count
//  APB       | in  | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// After reset a clearing pass zeroes the memories, one slot a cycle, all TOWNS*AGES*9
// slots (4608 by default); no request is taken meanwhile, APB writes are.
// A census or a move makes one memory read, then one write per cycle through the single
// saturating unit. A report walks the (town, age) range with one accumulate each for
// current and new counts per cell. A report that is turned away goes straight to the
// hand-off; an ignored move or an unused mode leaves the sequencer idle.
// The result sits in an output register; a pending result does not block new requests,
// only the next report's hand-off.
module grouped_compartment_counter_bank_core #(
    parameter int TOWNS       = 64,
    parameter int AGES        = 8,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    gccb_in_if.sink                      i_item,
    gccb_out_if.source                   o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gccb_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import gccb_pkg::*;

    localparam int NCELL = TOWNS * AGES;
    localparam int NSLOT = NCELL * 9;
    localparam int SW    = $clog2(NSLOT);
    localparam int CLW   = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int TW    = (TOWNS > 1) ? $clog2(TOWNS) : 1;
    localparam int AGW   = (AGES > 1) ? $clog2(AGES) : 1;
    localparam int AW    = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_C1, S_C2, S_M1, S_M2, S_M3, S_RRD, S_RCUR, S_RNEW, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [SW-1:0]          r_clr, n_clr;
    logic [1:0]             r_mode, n_mode;
    logic [TW-1:0]          r_t, n_t, r_tl, n_tl;
    logic [AGW-1:0]         r_a, n_a, r_a0, n_a0, r_al, n_al;
    logic [3:0]             r_src, n_src, r_dst, n_dst;
    logic [COUNT_WIDTH-1:0] r_tmp, n_tmp;
    logic [OUT_W-1:0]       r_cur, n_cur, r_nw, n_nw;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_W-1:0]       r_out_cur, n_out_cur, r_out_nw, n_out_nw;

    logic                   w_town_mode, w_age_mode;
    logic                   w_acc, w_in_rng, w_rep_ok, w_last;
    logic [TW-1:0]          w_t_nx;
    logic [AGW-1:0]         w_a_nx;
    logic [CLW-1:0]         w_cell, w_cell_nx, w_rd_cell;
    logic [SW-1:0]          w_slot_a, w_slot_b;
    logic                   w_rd_en;
    t_wr_en                 w_we;
    logic [SW-1:0]          w_pop_wa, w_new_wa, w_new_ra;
    logic [CLW-1:0]         w_tot_wa;
    logic [COUNT_WIDTH-1:0] w_pop_wd, w_new_wd, w_tot_wd;
    logic [COUNT_WIDTH-1:0] w_pop_a, w_pop_b, w_new, w_tot;
    t_alu_op                w_op;
    logic [AW-1:0]          w_alu_a, w_alu_b, w_alu_y;

    // slot address of one compartment of a cell
    function automatic logic [SW-1:0] slot_of(input logic [CLW-1:0] cell_idx,
                                               input logic [3:0] comp);
        logic [3:0] comp_m1;
        comp_m1 = (comp == COMP_TOTAL) ? 4'd0 : comp - 4'd1;
        return SW'(32'(cell_idx) * 9 + 32'(comp_m1));
    endfunction

    gccb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_town_mode (w_town_mode),
        .o_age_mode  (w_age_mode)
    );

    gccb_store #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .NSLOT       (NSLOT),
        .NCELL       (NCELL),
        .SW          (SW),
        .CLW         (CLW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rd_en  (w_rd_en),
        .i_we     (w_we),
        .i_pop_ra (w_slot_a),
        .i_pop_rb (w_slot_b),
        .i_new_ra (w_new_ra),
        .i_tot_ra (w_rd_cell),
        .i_pop_wa (w_pop_wa),
        .i_new_wa (w_new_wa),
        .i_tot_wa (w_tot_wa),
        .i_pop_wd (w_pop_wd),
        .i_new_wd (w_new_wd),
        .i_tot_wd (w_tot_wd),
        .o_pop_a  (w_pop_a),
        .o_pop_b  (w_pop_b),
        .o_new    (w_new),
        .o_tot    (w_tot)
    );

    gccb_alu #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_alu (
        .i_op (w_op),
        .i_a  (w_alu_a),
        .i_b  (w_alu_b),
        .o_y  (w_alu_y)
    );

    // request decode
    assign i_item.ready = (r_state == S_IDLE);
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_in_rng     = (32'(i_item.town) < TOWNS) && (32'(i_item.age_group) < AGES);
    assign w_rep_ok     = (i_item.source_state <= NCOMP)
                          && (!w_town_mode || (32'(i_item.town) < TOWNS))
                          && (!w_age_mode || (32'(i_item.age_group) < AGES));

    // report walk: current cell, next cell
    assign w_last    = (r_t == r_tl) && (r_a == r_al);
    assign w_a_nx    = (r_a == r_al) ? r_a0 : r_a + AGW'(1);
    assign w_t_nx    = (r_a == r_al) ? r_t + TW'(1) : r_t;
    assign w_cell    = CLW'(32'(r_t) * AGES + 32'(r_a));
    assign w_cell_nx = CLW'(32'(w_t_nx) * AGES + 32'(w_a_nx));
    assign w_rd_cell = (r_state == S_RNEW) ? w_cell_nx : w_cell;
    assign w_slot_a  = slot_of(w_rd_cell, r_src);
    assign w_slot_b  = slot_of(w_cell, r_dst);
    assign w_new_ra  = (r_mode == MODE_REPORT) ? w_slot_a : w_slot_b;

    assign w_rd_en = (r_state == S_RD) || (r_state == S_RRD)
                     || ((r_state == S_RNEW) && !w_last);

    // shared unit operand selection
    always_comb begin
        w_op    = ALU_INC;
        w_alu_a = AW'(w_pop_a);
        w_alu_b = '0;
        case (r_state)
            S_C1:   w_alu_a = AW'(w_tot);
            S_M1:   w_op    = ALU_DEC;
            S_M2:   w_alu_a = (r_src == r_dst) ? AW'(r_tmp) : AW'(w_pop_b);
            S_M3:   w_alu_a = AW'(w_new);
            S_RCUR: begin
                w_op    = ALU_ACC;
                w_alu_a = AW'(r_cur);
                w_alu_b = (r_src == COMP_TOTAL) ? AW'(w_tot) : AW'(w_pop_a);
            end
            S_RNEW: begin
                w_op    = ALU_ACC;
                w_alu_a = AW'(r_nw);
                w_alu_b = (r_src == COMP_TOTAL) ? '0 : AW'(w_new);
            end
            default: ;
        endcase
    end

    // memory writes
    always_comb begin
        w_we     = '0;
        w_pop_wa = w_slot_a;
        w_new_wa = w_slot_a;
        w_tot_wa = w_cell;
        w_pop_wd = w_alu_y[COUNT_WIDTH-1:0];
        w_new_wd = '0;
        w_tot_wd = w_alu_y[COUNT_WIDTH-1:0];
        case (r_state)
            S_CLR: begin
                w_we.pop = 1'b1;
                w_we.nw  = 1'b1;
                w_we.tot = (r_clr < SW'(NCELL));
                w_pop_wa = r_clr;
                w_new_wa = r_clr;
                w_tot_wa = r_clr[CLW-1:0];
                w_pop_wd = '0;
                w_tot_wd = '0;
            end
            S_C1:   w_we.tot = 1'b1;
            S_C2:   w_we.pop = 1'b1;
            S_M1:   w_we.pop = 1'b1;
            S_M2: begin
                w_we.pop = 1'b1;
                w_pop_wa = w_slot_b;
            end
            S_M3: begin
                w_we.nw  = 1'b1;
                w_new_wa = w_slot_b;
                w_new_wd = w_alu_y[COUNT_WIDTH-1:0];
            end
            // arrivals of the cell just read are cleared
            S_RCUR: w_we.nw = (r_src != COMP_TOTAL);
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_mode      = r_mode;
        n_t         = r_t;
        n_tl        = r_tl;
        n_a         = r_a;
        n_a0        = r_a0;
        n_al        = r_al;
        n_src       = r_src;
        n_dst       = r_dst;
        n_tmp       = r_tmp;
        n_cur       = r_cur;
        n_nw        = r_nw;
        n_out_valid = r_out_valid;
        n_out_cur   = r_out_cur;
        n_out_nw    = r_out_nw;

        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                n_clr = r_clr + SW'(1);
                if (r_clr == SW'(NSLOT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_mode = i_item.mode;
                    n_t    = TW'(i_item.town);
                    n_a    = AGW'(i_item.age_group);
                    n_src  = i_item.source_state;
                    n_dst  = i_item.target_state;
                    case (i_item.mode)
                        MODE_CENSUS: begin
                            n_src = (i_item.target_state == COMP_I) ? COMP_I : COMP_S;
                            if (w_in_rng) begin
                                n_state = S_RD;
                            end
                        end
                        MODE_MOVE: begin
                            if (w_in_rng && (i_item.source_state != COMP_TOTAL)
                                && (i_item.source_state <= NCOMP)
                                && (i_item.target_state != COMP_TOTAL)
                                && (i_item.target_state <= NCOMP)) begin
                                n_state = S_RD;
                            end
                        end
                        MODE_REPORT: begin
                            n_cur = '0;
                            n_nw  = '0;
                            n_t   = w_town_mode ? TW'(i_item.town) : '0;
                            n_tl  = w_town_mode ? TW'(i_item.town) : TW'(TOWNS - 1);
                            n_a   = w_age_mode ? AGW'(i_item.age_group) : '0;
                            n_a0  = n_a;
                            n_al  = w_age_mode ? AGW'(i_item.age_group) : AGW'(AGES - 1);
                            n_state = w_rep_ok ? S_RRD : S_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:   n_state = (r_mode == MODE_CENSUS) ? S_C1 : S_M1;
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_IDLE;
            S_M1: begin
                n_tmp   = w_alu_y[COUNT_WIDTH-1:0];
                n_state = S_M2;
            end
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_IDLE;
            S_RRD:  n_state = S_RCUR;
            S_RCUR: begin
                n_cur   = w_alu_y[OUT_W-1:0];
                n_state = S_RNEW;
            end
            S_RNEW: begin
                n_nw = w_alu_y[OUT_W-1:0];
                if (w_last) begin
                    n_state = S_OUT;
                end else begin
                    n_t     = w_t_nx;
                    n_a     = w_a_nx;
                    n_state = S_RCUR;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cur   = r_cur;
                    n_out_nw    = r_nw;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_mode      <= MODE_CENSUS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
        r_t       <= n_t;
        r_tl      <= n_tl;
        r_a       <= n_a;
        r_a0      <= n_a0;
        r_al      <= n_al;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_tmp     <= n_tmp;
        r_cur     <= n_cur;
        r_nw      <= n_nw;
        r_out_cur <= n_out_cur;
        r_out_nw  <= n_out_nw;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.current_count = r_out_cur;
    assign o_result.new_count     = r_out_nw;

    // no counter is written while waiting for a request
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_we == '0))
        else $error("memory written while idle");

    // totals change only in the clearing pass or a census
    a_tot_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we.tot |-> ((r_state == S_CLR) || (r_state == S_C1)))
        else $error("total written outside census");

    // an accepted report always leaves the idle state
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_item.mode == MODE_REPORT)) |=> (r_state != S_IDLE))
        else $error("report accepted but no walk started");

    // a result is only loaded at the end of a report
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside report end");

endmodule

FILE: dv/tb.sv
// Testbench for the grouped compartment counter bank: directed and random requests, scoreboard.
`timescale 1ns / 100ps

module tb;
    import gccb_pkg::*;

    localparam int TOWNS      = 64;
    localparam int AGES       = 8;
    localparam int CELLS      = TOWNS * AGES;
    localparam int SLOTS      = CELLS * 9;
    localparam int MAX_GAP    = 15;
    localparam int IDLE_LIMIT = 20000;  // clearing pass plus a full-range report, several times over
    localparam int SETTLE     = 16;     // a census or move still in flight
    localparam int DRAIN      = 64;
    localparam logic [23:0] CELL_MAX = 24'hFF_FFFF;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [3:0] COMP_V      = 4'd2;
    localparam logic [3:0] COMP_E      = 4'd3;
    localparam logic [3:0] COMP_D      = NCOMP;
    localparam logic [3:0] COMP_BAD_LO = 4'd10;
    localparam logic [3:0] COMP_BAD_HI = 4'd15;

    localparam logic [APB_AW-1:0] ADDR_TOWN_MODE = {REG_TOWN_MODE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_AGE_MODE  = {REG_AGE_MODE, 2'b00};

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] town;
        logic [2:0] age;
        logic [3:0] src;
        logic [3:0] dst;
    } t_census_req;

    typedef struct packed {
        logic [23:0] cur;
        logic [23:0] arr;
    } t_report;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    gccb_in_if  req_ch ();
    gccb_out_if res_ch ();

    grouped_compartment_counter_bank_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (req_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the counter bank and its mode registers
    bit [23:0] pop_cnt [SLOTS];
    bit [23:0] arr_cnt [SLOTS];
    bit [23:0] tot_cnt [CELLS];
    bit        town_sel;
    bit        age_sel;
    t_report   pending_reports[$];

    int mismatches;
    int quiet_cycles;
    bit burst;  // no idling on either side while set

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit [23:0] sat_inc(input bit [23:0] v);
        return (v == CELL_MAX) ? v : v + 24'd1;
    endfunction

    function automatic bit [23:0] sat_sum(input bit [23:0] acc, input bit [23:0] v);
        bit [24:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return (s > {1'b0, OUT_MAX}) ? OUT_MAX : s[23:0];
    endfunction

    function automatic int slot_of(input int t, input int a, input int c);
        return (t * AGES + a) * 9 + c - 1;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch, %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Update the shadow bank for one accepted request; a report queues its result.
    // Town and age fields cannot exceed TOWNS and AGES at these widths.
    function automatic void apply_request(input t_census_req r);
        int        ks, kd, t0, t1, a0, a1;
        bit        ok;
        bit [23:0] cur, arr;
        case (r.mode)
            MODE_CENSUS: begin
                kd = slot_of(r.town, r.age, (r.dst == COMP_I) ? COMP_I : COMP_S);
                tot_cnt[r.town * AGES + r.age] = sat_inc(tot_cnt[r.town * AGES + r.age]);
                pop_cnt[kd] = sat_inc(pop_cnt[kd]);
            end
            MODE_MOVE: begin
                if (r.src >= COMP_S && r.src <= NCOMP && r.dst >= COMP_S && r.dst <= NCOMP) begin
                    ks = slot_of(r.town, r.age, r.src);
                    kd = slot_of(r.town, r.age, r.dst);
                    if (pop_cnt[ks] != 0)
                        pop_cnt[ks] = pop_cnt[ks] - 24'd1;
                    pop_cnt[kd] = sat_inc(pop_cnt[kd]);
                    arr_cnt[kd] = sat_inc(arr_cnt[kd]);
                end
            end
            MODE_REPORT: begin
                cur = '0;
                arr = '0;
                ok  = (r.src <= NCOMP);
                t0 = town_sel ? int'(r.town) : 0;
                t1 = town_sel ? int'(r.town) + 1 : TOWNS;
                a0 = age_sel ? int'(r.age) : 0;
                a1 = age_sel ? int'(r.age) + 1 : AGES;
                if (ok) begin
                    for (int t = t0; t < t1; t++) begin
                        for (int a = a0; a < a1; a++) begin
                            if (r.src == COMP_TOTAL) begin
                                cur = sat_sum(cur, tot_cnt[t * AGES + a]);
                            end else begin
                                kd  = slot_of(t, a, r.src);
                                cur = sat_sum(cur, pop_cnt[kd]);
                                arr = sat_sum(arr, arr_cnt[kd]);
                                arr_cnt[kd] = '0;
                            end
                        end
                    end
                end
                pending_reports.push_back('{cur: cur, arr: arr});
            end
            default: ;
        endcase
    endfunction

    function automatic t_census_req mk_req(input logic [1:0] mode, input logic [5:0] town,
                                           input logic [2:0] age, input logic [3:0] src,
                                           input logic [3:0] dst);
        return '{mode: mode, town: town, age: age, src: src, dst: dst};
    endfunction

    // Random request: mostly well-formed traffic on a few busy cells, some noise
    function automatic t_census_req random_request(input int report_pct);
        t_census_req r;
        int          roll;
        int          pick;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 3);
        r.town = ($urandom_range(0, 3) != 0) ? ((pick < 2) ? 6'(pick) : 6'(60 + pick))
                                             : 6'($urandom);
        r.age  = ($urandom_range(0, 3) != 0) ? ($urandom_range(0, 1) ? 3'd7 : 3'd0)
                                             : 3'($urandom_range(0, 7));
        r.src  = 4'($urandom_range(COMP_S, NCOMP));
        r.dst  = 4'($urandom_range(COMP_S, NCOMP));
        if (roll < report_pct) begin
            r.mode = MODE_REPORT;
            r.src  = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(COMP_TOTAL, NCOMP))
                                                 : 4'($urandom_range(COMP_BAD_LO, COMP_BAD_HI));
            r.dst  = 4'($urandom);
        end else if (roll < report_pct + 5) begin
            r.mode = 2'($urandom_range(0, 3));
            r.src  = 4'($urandom);
            r.dst  = 4'($urandom);
        end else if (roll < report_pct + 5 + (95 - report_pct) * 45 / 100) begin
            r.mode = MODE_CENSUS;
            r.src  = 4'($urandom);
            r.dst  = ($urandom_range(0, 2) == 0) ? COMP_I : 4'($urandom);
        end else begin
            r.mode = MODE_MOVE;
            if ($urandom_range(0, 1))
                r.src = $urandom_range(0, 1) ? COMP_S : COMP_I;
        end
        return r;
    endfunction

    // Present one request after a random gap; entered and left at a falling edge
    task automatic send_request(input t_census_req r);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= r.mode;
        req_ch.town         <= r.town;
        req_ch.age_group    <= r.age;
        req_ch.source_state <= r.src;
        req_ch.target_state <= r.dst;
        do @(posedge i_clk); while (!req_ch.ready);
        apply_request(r);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for the bank to go idle
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // APB write followed by a read back of the same register
    task automatic apb_write_reg(input logic [APB_AW-1:0] addr, input bit v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'b0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== v)
            flag_mismatch($sformatf("read back of register at %0d", addr), v, prdata[0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input bit tm, input bit am);
        settle();
        apb_write_reg(ADDR_TOWN_MODE, tm);
        apb_write_reg(ADDR_AGE_MODE, am);
        town_sel = tm;
        age_sel  = am;
    endtask

    task automatic run_random(input int n, input int report_pct);
        for (int i = 0; i < n; i++) begin
            burst = ((i % 200) >= 150);
            send_request(random_request(report_pct));
        end
        burst = 1'b0;
    endtask

    // Extremes of the fields, every mode and each corner case
    task automatic test_directed();
        configure(1'b1, 1'b1);
        send_request(mk_req(MODE_REPORT, 6'd0, 3'd0, COMP_TOTAL, COMP_S));  // empty bank
        send_request(mk_req(MODE_CENSUS, 6'd63, 3'd7, COMP_TOTAL, COMP_I));
        send_request(mk_req(MODE_CENSUS, 6'd63, 3'd7, COMP_TOTAL, COMP_TOTAL));  // goes to S
        send_request(mk_req(MODE_CENSUS, 6'd63, 3'd7, COMP_BAD_HI, COMP_BAD_HI));
        send_request(mk_req(MODE_CENSUS, 6'd0, 3'd0, COMP_TOTAL, COMP_D));
        send_request(mk_req(MODE_MOVE, 6'd63, 3'd7, COMP_S, COMP_I));
        send_request(mk_req(MODE_MOVE, 6'd63, 3'd7, COMP_I, COMP_I));      // same compartment
        send_request(mk_req(MODE_MOVE, 6'd63, 3'd7, COMP_V, COMP_E));      // empty source holds
        send_request(mk_req(MODE_MOVE, 6'd63, 3'd7, COMP_TOTAL, COMP_E));  // ignored
        send_request(mk_req(MODE_MOVE, 6'd63, 3'd7, COMP_BAD_LO, COMP_E));
        send_request(mk_req(MODE_MOVE, 6'd63, 3'd7, COMP_S, COMP_TOTAL));
        send_request(mk_req(MODE_MOVE, 6'd63, 3'd7, COMP_S, COMP_BAD_HI));
        send_request(mk_req(MODE_UNUSED, 6'd63, 3'd7, COMP_S, COMP_I));
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd7, COMP_TOTAL, COMP_TOTAL));
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd7, COMP_I, COMP_TOTAL));
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd7, COMP_I, COMP_TOTAL));  // arrivals cleared
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd7, COMP_E, COMP_TOTAL));
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd7, COMP_D, COMP_TOTAL));
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd7, COMP_BAD_LO, COMP_TOTAL));
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd7, COMP_BAD_HI, COMP_BAD_HI));
        configure(1'b0, 1'b0);
        send_request(mk_req(MODE_REPORT, 6'd21, 3'd2, COMP_S, COMP_TOTAL));
        send_request(mk_req(MODE_REPORT, 6'd21, 3'd2, COMP_TOTAL, COMP_TOTAL));
        configure(1'b1, 1'b0);
        send_request(mk_req(MODE_REPORT, 6'd63, 3'd0, COMP_I, COMP_TOTAL));
        configure(1'b0, 1'b1);
        send_request(mk_req(MODE_REPORT, 6'd0, 3'd7, COMP_E, COMP_TOTAL));
    endtask

    task automatic test_single_cell();
        configure(1'b1, 1'b1);
        run_random(1000, 20);
    endtask

    task automatic test_town_range();
        configure(1'b1, 1'b0);
        run_random(400, 15);
    endtask

    task automatic test_age_range();
        configure(1'b0, 1'b1);
        run_random(300, 10);
    endtask

    task automatic test_full_range();
        configure(1'b0, 1'b0);
        run_random(200, 4);
    endtask

    // Result side: random stall before taking each result
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            @(negedge i_clk);
        end
    end

    // Compare each accepted result with the oldest pending report
    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("result with no report pending", 0, res_ch.current_count);
            end else begin
                want = pending_reports.pop_front();
                if (res_ch.current_count !== want.cur)
                    flag_mismatch("current_count", want.cur, res_ch.current_count);
                if (res_ch.new_count !== want.arr)
                    flag_mismatch("new_count", want.arr, res_ch.new_count);
            end
        end
    end

    // Watchdog on cycles with no request or result taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_CENSUS;
        req_ch.town         = '0;
        req_ch.age_group    = '0;
        req_ch.source_state = COMP_TOTAL;
        req_ch.target_state = COMP_TOTAL;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        town_sel            = 1'b0;
        age_sel             = 1'b0;
        burst               = 1'b0;
        mismatches          = 0;
        quiet_cycles        = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_single_cell();
        test_town_range();
        test_age_range();
        test_full_range();

        settle();
        repeat (DRAIN) @(negedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: grouped_compartment_counter_bank_core.f
design/gccb_pkg.sv
design/gccb_if.sv
design/gccb_regs.sv
design/gccb_alu.sv
design/gccb_store.sv
design/grouped_compartment_counter_bank_core.sv
dv/tb.sv
